[hw/rtl/keypad_shock_alarm_controller_macros.svh]
// Assertion helpers for the keypad shock alarm controller.
`ifndef KEYPAD_SHOCK_ALARM_CONTROLLER_MACROS_SVH
`define KEYPAD_SHOCK_ALARM_CONTROLLER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define KSAC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keypad shock alarm check failed");

// Check that cons holds in the cycle after ante.
`define KSAC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keypad shock alarm check failed");

`endif

[hw/rtl/ksac_pkg.sv]
package ksac_pkg;

   localparam int MAX_DIGITS   = 8;
   localparam int DIGIT_W      = 4;
   localparam int CODE_W       = 32;
   localparam int CODE_LEN_W   = 4;
   localparam int CODE_SLOTS   = CODE_W / DIGIT_W;
   localparam int MATCH_SLOTS  = (CODE_SLOTS < MAX_DIGITS) ? CODE_SLOTS : MAX_DIGITS;
   localparam int COUNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int ACCEL_W      = 15;
   localparam int THR_W        = 15;
   localparam int SQ_W         = 2 * ACCEL_W - 1;
   localparam int MAG_W        = SQ_W + 1;
   localparam int THR2_W       = 2 * THR_W;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [CODE_W-1:0]     DEFAULT_CODE      = 32'h0000_4321;
   localparam logic [CODE_LEN_W-1:0] DEFAULT_LEN       = 4'd4;
   localparam logic [THR_W-1:0]      DEFAULT_THRESHOLD = 15'd1500;

   localparam logic [DIGIT_W-1:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [DIGIT_W-1:0] KEY_CLEAR     = 4'd10;
   localparam logic [DIGIT_W-1:0] KEY_ENTER     = 4'd11;

   typedef enum logic [2:0] {
      MODE_KEY     = 3'd0,
      MODE_ACCEL   = 3'd1,
      MODE_ARM     = 3'd2,
      MODE_DISARM  = 3'd3,
      MODE_TEST    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      RESULT_NONE     = 2'd0,
      RESULT_ARMED    = 2'd1,
      RESULT_DISARMED = 2'd2,
      RESULT_WRONG    = 2'd3
   } code_result_type;

   typedef enum logic [1:0] {
      STATUS_DISARMED = 2'd0,
      STATUS_ARMED    = 2'd1,
      STATUS_ALARM    = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_DIGITS     = 3'd0,
      CSR_CODE_LENGTH     = 3'd1,
      CSR_SHOCK_THRESHOLD = 3'd2,
      CSR_SOUNDER_PRESENT = 3'd3
   } csr_index_type;

endpackage

[hw/rtl/keypad_shock_alarm_controller.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    mode, key, accel_x, accel_y, accel_z
// rsp       out        rsp_valid/rsp_ready    armed, alarm, siren_on, new_alarm,
//                                             key_beep, code_result, status
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One request per cycle while results are taken; results pass input then output register.
// Squares, magnitude compare, code compare and state update all settle between the two.
// Synchronous reset; no clearing pass, the block takes requests right after reset.
// A stalled result holds the output register; the input register takes one more request,
// then req_ready stays low until the result is taken. csr_ready is always high.
`include "keypad_shock_alarm_controller_macros.svh"

module keypad_shock_alarm_controller
   import ksac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_mode,
   input  logic [3:0]             req_key,
   input  logic signed [14:0]     req_accel_x,
   input  logic signed [14:0]     req_accel_y,
   input  logic signed [14:0]     req_accel_z,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_armed,
   output logic                   rsp_alarm,
   output logic                   rsp_siren_on,
   output logic                   rsp_new_alarm,
   output logic                   rsp_key_beep,
   output logic [1:0]             rsp_code_result,
   output logic [1:0]             rsp_status,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   logic [CODE_W-1:0]     code_digits_ff;
   logic [CODE_LEN_W-1:0] code_length_ff;
   logic [THR_W-1:0]      shock_threshold_ff;
   logic                  sounder_present_ff;
   logic [THR2_W-1:0]     thr2;

   logic                      s1_valid_ff;
   mode_type                  s1_mode_ff;
   logic [DIGIT_W-1:0]        s1_key_ff;
   logic signed [ACCEL_W-1:0] s1_x_ff;
   logic signed [ACCEL_W-1:0] s1_y_ff;
   logic signed [ACCEL_W-1:0] s1_z_ff;

   logic signed [2*ACCEL_W-1:0] x_prod;
   logic signed [2*ACCEL_W-1:0] y_prod;
   logic signed [2*ACCEL_W-1:0] z_prod;

   logic [DIGIT_W-1:0] entry_digits_ff [MAX_DIGITS];
   logic [COUNT_W-1:0] entry_count_ff;
   logic [COUNT_W-1:0] entry_count_in;
   logic               digit_wr;
   logic [IDX_W-1:0]   digit_idx;
   logic               armed_ff;
   logic               armed_in;
   logic               alarm_ff;
   logic               alarm_in;
   logic               siren_ff;
   logic               siren_in;

   logic               rsp_valid_ff;
   logic               rsp_armed_ff;
   logic               rsp_alarm_ff;
   logic               rsp_siren_ff;
   logic               rsp_new_alarm_ff;
   logic               rsp_new_alarm_in;
   logic               rsp_key_beep_ff;
   logic               rsp_key_beep_in;
   code_result_type    rsp_code_result_ff;
   code_result_type    rsp_code_result_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;

   logic [CODE_W-1:0]     code_eff;
   logic [CODE_LEN_W-1:0] len_eff;
   logic                  code_match;
   logic [MAG_W-1:0]      mag2;
   logic                  shock;

   logic out_ready;
   logic s1_ready;
   logic s1_fire;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_ready = s1_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         code_digits_ff     <= DEFAULT_CODE;
         code_length_ff     <= DEFAULT_LEN;
         shock_threshold_ff <= DEFAULT_THRESHOLD;
         sounder_present_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CODE_DIGITS:     code_digits_ff     <= csr_data[CODE_W-1:0];
            CSR_CODE_LENGTH:     code_length_ff     <= csr_data[CODE_LEN_W-1:0];
            CSR_SHOCK_THRESHOLD: shock_threshold_ff <= csr_data[THR_W-1:0];
            CSR_SOUNDER_PRESENT: sounder_present_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign thr2 = THR2_W'(shock_threshold_ff) * THR2_W'(shock_threshold_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_mode_ff <= mode_type'(req_mode);
         s1_key_ff  <= req_key;
         s1_x_ff    <= req_accel_x;
         s1_y_ff    <= req_accel_y;
         s1_z_ff    <= req_accel_z;
      end
   end

   // squares, code compare, shock detect, state update
   assign x_prod = s1_x_ff * s1_x_ff;
   assign y_prod = s1_y_ff * s1_y_ff;
   assign z_prod = s1_z_ff * s1_z_ff;

   always_comb begin
      code_eff   = (code_length_ff == '0) ? DEFAULT_CODE : code_digits_ff;
      len_eff    = (code_length_ff == '0) ? DEFAULT_LEN : code_length_ff;
      code_match = (32'(len_eff) <= 32'(CODE_SLOTS)) &&
                   (32'(len_eff) == 32'(entry_count_ff));
      for (int i = 0; i < MATCH_SLOTS; i++) begin
         if ((32'(i) < 32'(len_eff)) && (code_eff[DIGIT_W*i +: DIGIT_W] != entry_digits_ff[i]))
            code_match = 1'b0;
      end
   end

   assign mag2  = MAG_W'(x_prod[SQ_W-1:0]) + MAG_W'(y_prod[SQ_W-1:0]) +
                  MAG_W'(z_prod[SQ_W-1:0]);
   assign shock = mag2 > MAG_W'(thr2);

   always_comb begin
      armed_in           = armed_ff;
      alarm_in           = alarm_ff;
      siren_in           = siren_ff;
      entry_count_in     = entry_count_ff;
      digit_wr           = 1'b0;
      digit_idx          = entry_count_ff[IDX_W-1:0];
      rsp_new_alarm_in   = 1'b0;
      rsp_key_beep_in    = 1'b0;
      rsp_code_result_in = RESULT_NONE;
      case (s1_mode_ff)
         MODE_KEY: begin
            if (s1_key_ff == KEY_CLEAR) begin
               entry_count_in = '0;
            end else if (s1_key_ff == KEY_ENTER) begin
               if (code_match) begin
                  alarm_in = 1'b0;
                  if (armed_ff) begin
                     armed_in           = 1'b0;
                     rsp_code_result_in = RESULT_DISARMED;
                     if (sounder_present_ff)
                        siren_in = 1'b0;
                  end else begin
                     armed_in           = 1'b1;
                     rsp_code_result_in = RESULT_ARMED;
                  end
               end else begin
                  rsp_code_result_in = RESULT_WRONG;
               end
               entry_count_in = '0;
            end else if (s1_key_ff <= KEY_DIGIT_MAX) begin
               rsp_key_beep_in = !siren_ff && sounder_present_ff;
               if (32'(entry_count_ff) < 32'(MAX_DIGITS)) begin
                  digit_wr       = 1'b1;
                  entry_count_in = entry_count_ff + 1'b1;
               end else begin
                  entry_count_in = '0;
               end
            end
         end
         MODE_ACCEL: begin
            if (armed_ff && shock && !alarm_ff) begin
               alarm_in         = 1'b1;
               rsp_new_alarm_in = 1'b1;
               siren_in         = siren_ff || sounder_present_ff;
            end
         end
         MODE_ARM: begin
            armed_in = 1'b1;
            alarm_in = 1'b0;
         end
         MODE_DISARM: begin
            armed_in = 1'b0;
            alarm_in = 1'b0;
            if (sounder_present_ff)
               siren_in = 1'b0;
         end
         MODE_TEST: begin
            alarm_in = 1'b1;
            siren_in = siren_ff || sounder_present_ff;
         end
         default: ;
      endcase
      if (alarm_in)
         rsp_status_in = STATUS_ALARM;
      else if (armed_in)
         rsp_status_in = STATUS_ARMED;
      else
         rsp_status_in = STATUS_DISARMED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         armed_ff       <= 1'b0;
         alarm_ff       <= 1'b0;
         siren_ff       <= 1'b0;
      end else if (s1_fire) begin
         entry_count_ff <= entry_count_in;
         armed_ff       <= armed_in;
         alarm_ff       <= alarm_in;
         siren_ff       <= siren_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && digit_wr) begin
         entry_digits_ff[digit_idx] <= s1_key_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_armed_ff       <= armed_in;
         rsp_alarm_ff       <= alarm_in;
         rsp_siren_ff       <= siren_in;
         rsp_new_alarm_ff   <= rsp_new_alarm_in;
         rsp_key_beep_ff    <= rsp_key_beep_in;
         rsp_code_result_ff <= rsp_code_result_in;
         rsp_status_ff      <= rsp_status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_armed       = rsp_armed_ff;
   assign rsp_alarm       = rsp_alarm_ff;
   assign rsp_siren_on    = rsp_siren_ff;
   assign rsp_new_alarm   = rsp_new_alarm_ff;
   assign rsp_key_beep    = rsp_key_beep_ff;
   assign rsp_code_result = rsp_code_result_ff;
   assign rsp_status      = rsp_status_ff;

   `KSAC_ASSERT_NOW(a_new_alarm_when_armed, rsp_valid_ff && rsp_new_alarm_ff, rsp_armed_ff && rsp_alarm_ff)
   `KSAC_ASSERT_NOW(a_armed_by_code, rsp_valid_ff && (rsp_code_result_ff == RESULT_ARMED), rsp_armed_ff && !rsp_alarm_ff)
   `KSAC_ASSERT_NEXT(a_siren_needs_sounder, !sounder_present_ff && !siren_ff, !siren_ff)
   `KSAC_ASSERT_NOW(a_entry_count_bound, 1'b1, 32'(entry_count_ff) <= 32'(MAX_DIGITS))

endmodule

[sim/keypad_shock_alarm_controller_tb.sv]
`timescale 1ns / 100ps

module keypad_shock_alarm_controller_tb
   import ksac_pkg::*;
();

   localparam int LATENCY          = 1;
   localparam int SETTLE_CYCLES    = 2 * LATENCY;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 80;

   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
   localparam logic [3:0] KEY_SPARE_FIRST  = 4'd12;
   localparam logic [3:0] KEY_SPARE_LAST   = 4'd15;

   typedef struct packed {
      logic            armed;
      logic            alarm;
      logic            siren_on;
      logic            new_alarm;
      logic            key_beep;
      code_result_type code_result;
      status_type      status;
   } alarm_outcome_type;

   bit                    clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [2:0]            req_mode;
   logic [3:0]            req_key;
   logic signed [14:0]    req_accel_x;
   logic signed [14:0]    req_accel_y;
   logic signed [14:0]    req_accel_z;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_armed;
   logic                  rsp_alarm;
   logic                  rsp_siren_on;
   logic                  rsp_new_alarm;
   logic                  rsp_key_beep;
   logic [1:0]            rsp_code_result;
   logic [1:0]            rsp_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]           csr_data;

   logic [3:0]  typed_digits [MAX_DIGITS];
   int unsigned typed_count;
   logic        is_armed;
   logic        alarm_latched;
   logic        siren_sounding;
   logic [31:0] cfg_code;
   logic [3:0]  cfg_length;
   logic [14:0] cfg_threshold;
   logic        cfg_sounder;

   alarm_outcome_type expected_outcomes [$];
   int fail_count;
   int quiet_cycles;
   int rsp_hold_cycles;
   bit idle_on;

   keypad_shock_alarm_controller i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_key         (req_key),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_armed       (rsp_armed),
      .rsp_alarm       (rsp_alarm),
      .rsp_siren_on    (rsp_siren_on),
      .rsp_new_alarm   (rsp_new_alarm),
      .rsp_key_beep    (rsp_key_beep),
      .rsp_code_result (rsp_code_result),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic forget_typed_digits();
      foreach (typed_digits[i]) typed_digits[i] = '0;
      typed_count = 0;
   endtask

   function automatic bit entry_matches_code();
      logic [31:0] code;
      int          len;
      code = cfg_code;
      len  = cfg_length;
      if (len == 0) begin
         code = DEFAULT_CODE;
         len  = DEFAULT_LEN;
      end
      if (len > MAX_DIGITS || typed_count != len) return 1'b0;
      for (int i = 0; i < len; i++) begin
         if (code[4*i +: 4] != typed_digits[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_alarm_outcome(input logic [2:0] mode, input logic [3:0] key,
                                        input logic signed [14:0] ax, ay, az);
      alarm_outcome_type o;
      longint            mag2;
      longint            thr2;
      o = '0;
      o.code_result = RESULT_NONE;
      case (mode)
         MODE_KEY: begin
            if (key == KEY_CLEAR) begin
               forget_typed_digits();
            end else if (key == KEY_ENTER) begin
               if (entry_matches_code()) begin
                  if (is_armed) begin
                     is_armed      = 1'b0;
                     alarm_latched = 1'b0;
                     if (cfg_sounder) siren_sounding = 1'b0;
                     o.code_result = RESULT_DISARMED;
                  end else begin
                     is_armed      = 1'b1;
                     alarm_latched = 1'b0;
                     o.code_result = RESULT_ARMED;
                  end
               end else begin
                  o.code_result = RESULT_WRONG;
               end
               forget_typed_digits();
            end else if (key <= KEY_DIGIT_MAX) begin
               o.key_beep = !siren_sounding && cfg_sounder;
               if (typed_count < MAX_DIGITS) begin
                  typed_digits[typed_count] = key;
                  typed_count++;
               end else begin
                  forget_typed_digits();
               end
            end
         end
         MODE_ACCEL: begin
            mag2 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
            thr2 = longint'(cfg_threshold) * longint'(cfg_threshold);
            if (is_armed && mag2 > thr2 && !alarm_latched) begin
               alarm_latched = 1'b1;
               o.new_alarm   = 1'b1;
               if (cfg_sounder) siren_sounding = 1'b1;
            end
         end
         MODE_ARM: begin
            is_armed      = 1'b1;
            alarm_latched = 1'b0;
         end
         MODE_DISARM: begin
            is_armed      = 1'b0;
            alarm_latched = 1'b0;
            if (cfg_sounder) siren_sounding = 1'b0;
         end
         MODE_TEST: begin
            alarm_latched = 1'b1;
            if (cfg_sounder) siren_sounding = 1'b1;
         end
         default: ;
      endcase
      o.armed    = is_armed;
      o.alarm    = alarm_latched;
      o.siren_on = siren_sounding;
      o.status   = alarm_latched ? STATUS_ALARM : (is_armed ? STATUS_ARMED : STATUS_DISARMED);
      expected_outcomes.push_back(o);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic check_outcome();
      alarm_outcome_type want;
      if (expected_outcomes.size() == 0) begin
         report_mismatch("result with no request outstanding");
      end else begin
         want = expected_outcomes.pop_front();
         check_field("armed", rsp_armed, want.armed);
         check_field("alarm", rsp_alarm, want.alarm);
         check_field("siren_on", rsp_siren_on, want.siren_on);
         check_field("new_alarm", rsp_new_alarm, want.new_alarm);
         check_field("key_beep", rsp_key_beep, want.key_beep);
         check_field("code_result", rsp_code_result, want.code_result);
         check_field("status", rsp_status, want.status);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_code       = DEFAULT_CODE;
         cfg_length     = DEFAULT_LEN;
         cfg_threshold  = DEFAULT_THRESHOLD;
         cfg_sounder    = 1'b1;
         is_armed       = 1'b0;
         alarm_latched  = 1'b0;
         siren_sounding = 1'b0;
         forget_typed_digits();
         expected_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CODE_DIGITS:     cfg_code      = csr_data;
               CSR_CODE_LENGTH:     cfg_length    = csr_data[3:0];
               CSR_SHOCK_THRESHOLD: cfg_threshold = csr_data[14:0];
               CSR_SOUNDER_PRESENT: cfg_sounder   = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_outcome();
         if (req_valid && req_ready)
            predict_alarm_outcome(req_mode, req_key, req_accel_x, req_accel_y, req_accel_z);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles - 1) @(negedge clock);
            rsp_hold_cycles = 0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [2:0] mode, input logic [3:0] key,
                               input logic signed [14:0] ax, ay, az);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_key     <= key;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_key(input logic [3:0] key);
      send_request(MODE_KEY, key, '0, '0, '0);
   endtask

   task automatic send_accel(input logic signed [14:0] ax, ay, az);
      send_request(MODE_ACCEL, '0, ax, ay, az);
   endtask

   task automatic send_command(input logic [2:0] mode);
      send_request(mode, '0, '0, '0, '0);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] code, input logic [3:0] length,
                                 input logic [14:0] threshold, input logic sounder);
      wait_for_drain();
      write_register(CSR_CODE_DIGITS, code);
      write_register(CSR_CODE_LENGTH, {28'd0, length});
      write_register(CSR_SHOCK_THRESHOLD, {17'd0, threshold});
      write_register(CSR_SOUNDER_PRESENT, {31'd0, sounder});
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [14:0] random_axis(input int thr);
      int v;
      case ($urandom_range(0, 2))
         0: v = $urandom;
         1: begin
            v = thr + $urandom_range(0, 4) - 2;
            if (v > 16383) v = 16383;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = $urandom_range(0, 200) - 100;
      endcase
      return v[14:0];
   endfunction

   task automatic random_settings();
      logic [31:0] code;
      logic [3:0]  length;
      logic [14:0] threshold;
      for (int i = 0; i < 8; i++) code[4*i +: 4] = 4'($urandom_range(0, 9));
      if ($urandom_range(0, 7) == 0) code = $urandom;
      length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
      threshold = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                              : 15'($urandom_range(300, 12000));
      apply_settings(code, length, threshold, $urandom_range(0, 3) != 0);
   endtask

   task automatic random_traffic(input int items);
      int          sent;
      int          pick;
      int          len;
      logic [31:0] code;
      logic [31:0] noise_a;
      logic [31:0] noise_b;
      logic [2:0]  mode;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            code = (cfg_length == 0) ? DEFAULT_CODE : cfg_code;
            len  = (cfg_length == 0) ? DEFAULT_LEN : cfg_length;
            if (len > MAX_DIGITS) len = MAX_DIGITS;
            for (int i = 0; i < len; i++) send_key(code[4*i +: 4]);
            send_key(KEY_ENTER);
            sent += len + 1;
         end else if (pick < 45) begin
            len = $urandom_range(0, MAX_DIGITS + 1);
            for (int i = 0; i < len; i++) send_key(4'($urandom_range(0, 9)));
            send_key(KEY_ENTER);
            sent += len + 1;
         end else if (pick < 75) begin
            send_accel(random_axis(cfg_threshold), random_axis(cfg_threshold),
                       random_axis(cfg_threshold));
            sent++;
         end else if (pick < 83) begin
            noise_a = $urandom;
            noise_b = $urandom;
            mode = 3'(MODE_ARM + $urandom_range(0, 2));
            send_request(mode, noise_a[3:0], noise_a[18:4], noise_b[14:0], noise_b[29:15]);
            sent++;
         end else if (pick < 88) begin
            send_key(KEY_CLEAR);
            sent++;
         end else if (pick < 93) begin
            send_key(4'($urandom_range(0, 15)));
            sent++;
         end else begin
            noise_a = $urandom;
            noise_b = $urandom;
            send_request(noise_a[2:0], noise_a[6:3], noise_a[21:7], noise_b[14:0],
                         noise_b[29:15]);
            sent++;
         end
      end
   endtask

   task automatic test_default_code();
      send_key(1);
      send_key(2);
      send_key(3);
      send_key(4);
      send_key(KEY_ENTER);
      send_accel(15'sd1500, 15'sd0, 15'sd0);
      send_accel(15'sd1501, 15'sd0, 15'sd0);
      send_accel(-15'sd16384, -15'sd16384, -15'sd16384);
      send_key(5);
      send_key(KEY_CLEAR);
      send_key(1);
      send_key(2);
      send_key(3);
      send_key(4);
      send_key(KEY_ENTER);
      send_key(KEY_SPARE_FIRST);
      send_key(KEY_SPARE_LAST);
      send_command(MODE_SPARE_FIRST);
      send_command(MODE_SPARE_LAST);
      send_command(MODE_TEST);
      send_command(MODE_DISARM);
      send_command(MODE_ARM);
      send_key(9);
      send_key(KEY_ENTER);
      send_accel(15'sd16383, 15'sd16383, 15'sd16383);
   endtask

   task automatic test_code_length();
      apply_settings(32'h8765_4321, 4'd8, DEFAULT_THRESHOLD, 1'b1);
      for (int i = 1; i <= 8; i++) send_key(4'(i));
      send_key(KEY_ENTER);
      for (int i = 1; i <= 9; i++) send_key(4'(i));
      send_key(KEY_ENTER);
      send_command(MODE_DISARM);
      apply_settings(32'hFFFF_FFFF, 4'd0, DEFAULT_THRESHOLD, 1'b1);
      for (int i = 1; i <= 4; i++) send_key(4'(i));
      send_key(KEY_ENTER);
      apply_settings(32'h0000_0001, 4'd9, DEFAULT_THRESHOLD, 1'b1);
      send_key(1);
      send_key(KEY_ENTER);
      apply_settings(32'h0000_00A5, 4'd2, DEFAULT_THRESHOLD, 1'b1);
      send_key(5);
      send_key(KEY_ENTER);
      apply_settings(32'hFFFF_FFFF, 4'd15, DEFAULT_THRESHOLD, 1'b1);
      send_key(KEY_ENTER);
   endtask

   task automatic test_shock_threshold();
      apply_settings(DEFAULT_CODE, DEFAULT_LEN, 15'd0, 1'b0);
      send_command(MODE_ARM);
      send_accel(15'sd0, 15'sd0, 15'sd0);
      send_key(3);
      send_accel(15'sd1, 15'sd0, 15'sd0);
      send_command(MODE_TEST);
      send_command(MODE_DISARM);
      apply_settings(DEFAULT_CODE, DEFAULT_LEN, 15'd32767, 1'b1);
      send_command(MODE_ARM);
      send_accel(-15'sd16384, -15'sd16384, -15'sd16384);
      send_accel(15'sd16383, 15'sd16383, 15'sd16383);
      send_command(MODE_TEST);
      send_key(7);
      send_command(MODE_DISARM);
      send_command(MODE_TEST);
      apply_settings(DEFAULT_CODE, DEFAULT_LEN, 15'd32767, 1'b0);
      send_command(MODE_DISARM);
      send_key(0);
      send_command(MODE_ARM);
      for (int i = 1; i <= 4; i++) send_key(4'(i));
      send_key(KEY_ENTER);
   endtask

   task automatic test_receiver_stall();
      apply_settings(DEFAULT_CODE, DEFAULT_LEN, DEFAULT_THRESHOLD, 1'b1);
      rsp_hold_cycles = LONG_HOLD_CYCLES;
      random_traffic(40);
      wait_for_drain();
   endtask

   task automatic test_random_phases();
      repeat (6) begin
         random_settings();
         random_traffic(120);
      end
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      random_settings();
      random_traffic(100);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = '0;
      req_key     = '0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      idle_on     = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_default_code();
      test_code_length();
      test_shock_threshold();
      test_receiver_stall();
      test_random_phases();
      test_steady_stream();
      wait_for_drain();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
